[hw/rtl/lsp_pkg.sv]
// Shared types, widths, codes and helpers of the looping sample player.
package lsp_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_TRIGGER = 2'd1,
    OP_TICK    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [2:0] REG_RATE          = 3'd0;
  localparam logic [2:0] REG_LOOP_START    = 3'd1;
  localparam logic [2:0] REG_LOOP_END      = 3'd2;
  localparam logic [2:0] REG_SAMPLE_LENGTH = 3'd3;
  localparam logic [2:0] REG_ONE_SHOT      = 3'd4;
  localparam logic [2:0] REG_INTERP_MODE   = 3'd5;
  localparam logic [2:0] REG_SAMPLE_VALID  = 3'd6;

  localparam logic [16:0] INDEX_CAP = 17'h10000;

  // Clips a signed value to the signed 16-bit range.
  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

endpackage

[hw/rtl/lsp_if.sv]
// Valid/ready stream interfaces for input items and output samples.
interface lsp_in_if;
  logic                                valid;
  logic                                ready;
  logic [lsp_pkg::OP_W-1:0]            op;
  logic [lsp_pkg::ADDR_W-1:0]          address;
  logic signed [lsp_pkg::DATA_W-1:0]   data;

  modport source (output valid, op, address, data, input ready);
  modport sink   (input valid, op, address, data, output ready);
endinterface

interface lsp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lsp_pkg::DATA_W-1:0]   sample_out;
  logic                                active;

  modport source (output valid, sample_out, active, input ready);
  modport sink   (input valid, sample_out, active, output ready);
endinterface

[hw/rtl/lsp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module lsp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/looping_sample_player_top.sv]
// Top level of the looping sample player voice.
//
// One sample-playback voice. Load beats write signed 16-bit words into the
// sample RAM, a trigger beat rewinds the play position to the loop start and
// starts play, and every tick beat returns exactly one output beat. Load and
// trigger beats return nothing. A silent tick (not playing or no valid sample)
// goes straight to the output step, as does a tick whose tap window is empty
// once the position is stepped. A playing tick uses linear or cubic Hermite
// interpolation: after the beat is taken, the clamp, wrap and step states
// wrap and step the position, each tap is read in turn on the single RAM read
// port (two or four taps), and a wait state lets the last read land. The shared
// 30 by 18 bit multiplier then runs four sequencer steps for linear or seven
// for cubic, and a last step hands the beat to the output register. A stalled
// output keeps the voice in that last step. The input is not ready while a
// tick is being worked on; a finished output beat waits in its own register,
// so the next item can be taken before it is drained. Configuration is to be
// written through the APB port only while the voice is idle; the user must
// keep to this, as the block does not enforce it. pready is always high.
module looping_sample_player_top #(
  parameter int unsigned STORE_DEPTH = 65536,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lsp_in_if.sink              in_i,
  lsp_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned AW    = $clog2(STORE_DEPTH);
  localparam int unsigned POS_W = 17 + FRAC_BITS;
  localparam int unsigned MA_W  = 30;
  localparam int unsigned MB_W  = FRAC_BITS + 2;
  localparam int unsigned P_W   = MA_W + MB_W;
  localparam int unsigned ACC_W = P_W + 1;
  localparam logic [16:0] CAP   = (STORE_DEPTH < 65536) ? 17'(STORE_DEPTH) : 17'h10000;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CLAMP = 8'b00000010,
    S_WRAP  = 8'b00000100,
    S_STEP  = 8'b00001000,
    S_READ  = 8'b00010000,
    S_WAIT  = 8'b00100000,
    S_MUL   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic signed [23:0] rate_q;
  logic [15:0]        loop_start_q;
  logic [16:0]        loop_end_q;
  logic [16:0]        sample_length_q;
  logic               one_shot_q;
  logic               interp_mode_q;
  logic               sample_valid_q;

  // Voice state and sequencer.
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               playing_q, playing_d;
  logic [1:0]         k_q, k_d;
  logic [2:0]         s_q, s_d;
  logic               rd_pend_q;
  logic [1:0]         rd_tag_q;
  logic               out_valid_q, out_valid_d;

  // Datapath registers.
  logic signed [15:0]      tap_q [4];
  logic signed [P_W-1:0]   p_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [15:0]      res_q, res_d;
  logic signed [15:0]      out_sample_q;
  logic                    out_active_q;

  logic cfg_we;
  assign cfg_we = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[4:2])
      lsp_pkg::REG_RATE:          prdata = 32'(rate_q);
      lsp_pkg::REG_LOOP_START:    prdata = {16'd0, loop_start_q};
      lsp_pkg::REG_LOOP_END:      prdata = {15'd0, loop_end_q};
      lsp_pkg::REG_SAMPLE_LENGTH: prdata = {15'd0, sample_length_q};
      lsp_pkg::REG_ONE_SHOT:      prdata = {31'd0, one_shot_q};
      lsp_pkg::REG_INTERP_MODE:   prdata = {31'd0, interp_mode_q};
      lsp_pkg::REG_SAMPLE_VALID:  prdata = {31'd0, sample_valid_q};
      default:                    prdata = 32'd0;
    endcase
  end

  // Window bounds: positions in fixed point, tap limit as the least of the
  // loop end, the sample length and the RAM depth.
  logic [POS_W-1:0] st_pos, en_pos;
  logic [16:0]      lim, lim_a;
  logic             win_empty;
  logic             rate_pos;
  logic [23:0]      rate_mag;

  assign st_pos    = POS_W'(loop_start_q) << FRAC_BITS;
  assign en_pos    = POS_W'(loop_end_q) << FRAC_BITS;
  assign lim_a     = (sample_length_q < loop_end_q) ? sample_length_q : loop_end_q;
  assign lim       = (CAP < lim_a) ? CAP : lim_a;
  assign win_empty = (lim <= {1'b0, loop_start_q});
  assign rate_pos  = !rate_q[23] && (rate_q != 24'sd0);
  assign rate_mag  = 24'(-rate_q);

  // Tap index for the current read slot, clamped to the window.
  logic [16:0]        ip;
  logic [FRAC_BITS-1:0] frac;
  logic signed [18:0] tap_idx;
  logic [16:0]        tap_clip;

  assign ip      = pos_q[POS_W-1:FRAC_BITS];
  assign frac    = pos_q[FRAC_BITS-1:0];
  assign tap_idx = $signed({2'b00, ip}) + $signed({17'd0, k_q}) - 19'sd1;

  always_comb begin
    if (tap_idx < $signed({3'b000, loop_start_q})) begin
      tap_clip = {1'b0, loop_start_q};
    end else if (tap_idx >= $signed({2'b00, lim})) begin
      tap_clip = lim - 17'd1;
    end else begin
      tap_clip = tap_idx[16:0];
    end
  end

  // Sample RAM.
  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [15:0]       ram_rdata;

  assign ram_we    = in_i.valid && in_i.ready && (in_i.op == lsp_pkg::OP_LOAD)
                     && (32'(in_i.address) < STORE_DEPTH);
  assign ram_raddr = AW'(tap_clip[15:0]);

  lsp_ram #(
    .WIDTH (16),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(in_i.address)),
    .wdata_i (in_i.data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Hermite coefficients from the four captured taps.
  logic signed [20:0] ta, tb, tc, td;
  logic signed [20:0] a1, a2, a3;

  assign ta = 21'(tap_q[0]);
  assign tb = 21'(tap_q[1]);
  assign tc = 21'(tap_q[2]);
  assign td = 21'(tap_q[3]);
  assign a3 = td - ta + 21'sd3 * (tb - tc);
  assign a2 = 21'sd2 * ta - 21'sd5 * tb + 21'sd4 * tc - td;
  assign a1 = tc - ta;

  // Shared multiplier.
  logic signed [MA_W-1:0] mul_a;
  logic [FRAC_BITS:0]     mul_u;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0]  mul_p;

  always_comb begin
    mul_a = MA_W'(acc_q);
    mul_u = {1'b0, frac};
    if (!interp_mode_q) begin
      if (s_q == 3'd0) begin
        mul_a = MA_W'(tap_q[1]);
        mul_u = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
      end else begin
        mul_a = MA_W'(tap_q[2]);
      end
    end else if (s_q == 3'd0) begin
      mul_a = MA_W'(a3) <<< 8;
    end
  end

  assign mul_b = $signed({1'b0, mul_u});
  assign mul_p = P_W'(mul_a) * P_W'(mul_b);

  logic signed [ACC_W-1:0] p_sh;
  logic signed [ACC_W-1:0] half;
  assign p_sh = ACC_W'(p_q >>> FRAC_BITS);
  assign half = ACC_W'(1) <<< (FRAC_BITS - 1);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    playing_d   = playing_q;
    k_d         = k_q;
    s_d         = s_q;
    acc_d       = acc_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          case (in_i.op)
            lsp_pkg::OP_TRIGGER: begin
              pos_d     = st_pos;
              playing_d = 1'b1;
            end
            lsp_pkg::OP_TICK: begin
              res_d = 16'sd0;
              if (sample_valid_q && playing_q) begin
                state_d = S_CLAMP;
              end else begin
                state_d = S_OUT;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLAMP: begin
        if (rate_pos) begin
          if (pos_q < st_pos) pos_d = st_pos;
        end else if (pos_q <= st_pos) begin
          pos_d = en_pos;
        end
        state_d = S_WRAP;
      end
      S_WRAP: begin
        if (rate_pos && (pos_q >= en_pos)) begin
          pos_d = st_pos;
          if (one_shot_q) playing_d = 1'b0;
        end
        state_d = S_STEP;
      end
      S_STEP: begin
        if (rate_pos) begin
          pos_d = pos_q + POS_W'($unsigned(rate_q));
        end else if (pos_q >= POS_W'(rate_mag)) begin
          pos_d = pos_q - POS_W'(rate_mag);
        end else begin
          pos_d = '0;
        end
        if (win_empty) begin
          res_d   = 16'sd0;
          state_d = S_OUT;
        end else begin
          k_d     = interp_mode_q ? 2'd0 : 2'd1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (k_q == (interp_mode_q ? 2'd3 : 2'd2)) begin
          state_d = S_WAIT;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      S_WAIT: begin
        s_d     = 3'd0;
        state_d = S_MUL;
      end
      S_MUL: begin
        s_d = s_q + 3'd1;
        if (!interp_mode_q) begin
          case (s_q)
            3'd0: acc_d = acc_q;
            3'd1: acc_d = ACC_W'(p_q);
            3'd2: acc_d = acc_q + ACC_W'(p_q) + half;
            default: begin
              res_d   = lsp_pkg::sat16(32'(acc_q >>> FRAC_BITS));
              state_d = S_OUT;
            end
          endcase
        end else begin
          case (s_q)
            3'd0, 3'd2, 3'd4: acc_d = acc_q;
            3'd1: acc_d = p_sh + (ACC_W'(a2) <<< 8);
            3'd3: acc_d = p_sh + (ACC_W'(a1) <<< 8);
            3'd5: acc_d = p_sh;
            default: begin
              res_d   = lsp_pkg::sat16(32'(tap_q[1])
                                       + 32'((acc_q + ACC_W'(256)) >>> 9));
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_OUT: begin
        // The finished beat waits here until the output register is free.
        if (!out_valid_d) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      rate_q          <= 24'sd65536;
      loop_start_q    <= '0;
      loop_end_q      <= '0;
      sample_length_q <= '0;
      one_shot_q      <= 1'b0;
      interp_mode_q   <= 1'b0;
      sample_valid_q  <= 1'b0;
      pos_q           <= '0;
      playing_q       <= 1'b0;
      k_q             <= '0;
      s_q             <= '0;
      rd_pend_q       <= 1'b0;
      rd_tag_q        <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      playing_q   <= playing_d;
      k_q         <= k_d;
      s_q         <= s_d;
      rd_pend_q   <= (state_q == S_READ);
      rd_tag_q    <= k_q;
      out_valid_q <= out_valid_d;
      if (cfg_we) begin
        case (paddr[4:2])
          lsp_pkg::REG_RATE:          rate_q <= $signed(pwdata[23:0]);
          lsp_pkg::REG_LOOP_START:    loop_start_q <= pwdata[15:0];
          lsp_pkg::REG_LOOP_END:
            loop_end_q <= (pwdata[16:0] > lsp_pkg::INDEX_CAP) ? lsp_pkg::INDEX_CAP
                                                              : pwdata[16:0];
          lsp_pkg::REG_SAMPLE_LENGTH:
            sample_length_q <= (pwdata[16:0] > lsp_pkg::INDEX_CAP) ? lsp_pkg::INDEX_CAP
                                                                   : pwdata[16:0];
          lsp_pkg::REG_ONE_SHOT:      one_shot_q <= pwdata[0];
          lsp_pkg::REG_INTERP_MODE:   interp_mode_q <= pwdata[0];
          lsp_pkg::REG_SAMPLE_VALID:  sample_valid_q <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      tap_q[rd_tag_q] <= $signed(ram_rdata);
    end
    p_q   <= mul_p;
    acc_q <= acc_d;
    res_q <= res_d;
    if (state_q == S_OUT && !out_valid_q) begin
      out_sample_q <= res_q;
      out_active_q <= playing_q;
    end else if (state_q == S_OUT && out_o.ready) begin
      out_sample_q <= res_q;
      out_active_q <= playing_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_sample_q;
  assign out_o.active     = out_active_q;

endmodule

[verif/looping_sample_player_top_tb.sv]
// Self-checking testbench for the looping sample player top level.
`timescale 1ns / 1ps

module looping_sample_player_top_tb;

  typedef struct packed {
    lsp_pkg::op_e       op;
    logic [15:0]        address;
    logic signed [15:0] data;
  } voice_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               active;
  } voice_sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lsp_in_if  in_bus ();
  lsp_out_if out_bus ();

  looping_sample_player_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #2 clk_i = ~clk_i;

  // Beats waiting to be offered, and samples the voice still owes us.
  voice_item_t   pending_items[$];
  voice_sample_t owed_samples[$];
  int unsigned   mismatches = 0;
  int unsigned   sender_idle_pct = 7;
  int unsigned   recv_idle_pct = 58;
  int unsigned   hold_off_req = 0;
  int unsigned   hold_off_cnt = 0;
  logic          in_fire = 1'b0;

  // Shadow copy of the voice: configuration, play state and sample RAM.
  longint             sh_rate = 65536;
  longint             sh_loop_start = 0;
  longint             sh_loop_end = 0;
  longint             sh_length = 0;
  bit                 sh_one_shot = 0;
  bit                 sh_cubic = 0;
  bit                 sh_valid = 0;
  longint             play_pos = 0;
  bit                 playing = 0;
  logic signed [15:0] sample_ram [65536];

  initial begin
    in_bus.valid   = 1'b0;
    in_bus.op      = lsp_pkg::OP_NONE;
    in_bus.address = '0;
    in_bus.data    = '0;
    out_bus.ready  = 1'b0;
  end

  function automatic longint read_tap(longint i, longint lo, longint hi);
    if (i < lo) begin
      i = lo;
    end
    if (i > hi) begin
      i = hi;
    end
    return longint'(sample_ram[i]);
  endfunction

  // Wraps and steps the play position, then interpolates the RAM there.
  function automatic voice_sample_t play_tick();
    voice_sample_t res;
    longint st, en, lo, hi, ip, f, a, b, c, d, h, v;
    v = 0;
    if (sh_valid && playing) begin
      st = sh_loop_start <<< 16;
      en = sh_loop_end <<< 16;
      if (sh_rate > 0) begin
        if (play_pos < st) begin
          play_pos = st;
        end
        if (play_pos >= en) begin
          if (sh_one_shot) begin
            playing = 0;
          end
          play_pos = st;
        end
        play_pos = play_pos + sh_rate;
      end else begin
        // A zero rate goes this way too: it parks at the loop end.
        if (play_pos <= st) begin
          play_pos = en;
        end
        play_pos = (play_pos >= -sh_rate) ? play_pos + sh_rate : 0;
      end
      lo = sh_loop_start;
      hi = ((sh_loop_end < sh_length) ? sh_loop_end : sh_length) - 1;
      if (hi >= lo) begin
        ip = play_pos >>> 16;
        f  = play_pos & 64'hffff;
        b  = read_tap(ip, lo, hi);
        c  = read_tap(ip + 1, lo, hi);
        if (!sh_cubic) begin
          h = b * (65536 - f) + c * f + 32768;
          v = h >>> 16;
        end else begin
          a = read_tap(ip - 1, lo, hi);
          d = read_tap(ip + 2, lo, hi);
          h = (d - a + 3 * (b - c)) * 256;
          h = ((h * f) >>> 16) + (2 * a - 5 * b + 4 * c - d) * 256;
          h = ((h * f) >>> 16) + (c - a) * 256;
          h = (h * f) >>> 16;
          v = b + ((h + 256) >>> 9);
        end
        if (v > 32767) begin
          v = 32767;
        end else if (v < -32768) begin
          v = -32768;
        end
      end
    end
    res.sample_out = v[15:0];
    res.active     = playing;
    return res;
  endfunction

  // Driver: a new beat goes out at the falling edge once the last one was taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_bus.valid || in_fire)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        voice_item_t it;
        it = pending_items.pop_front();
        in_bus.op      <= it.op;
        in_bus.address <= it.address;
        in_bus.data    <= it.data;
        in_bus.valid   <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_off_req != 0) begin
      hold_off_cnt = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_off_cnt != 0) begin
      hold_off_cnt = hold_off_cnt - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on every accepted input beat, checks every output beat.
  always @(posedge clk_i) begin
    voice_sample_t got, want;
    in_fire <= in_bus.valid && in_bus.ready;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      case (in_bus.op)
        lsp_pkg::OP_LOAD:    sample_ram[in_bus.address] = in_bus.data;
        lsp_pkg::OP_TRIGGER: begin
          play_pos = sh_loop_start <<< 16;
          playing  = 1;
        end
        lsp_pkg::OP_TICK:    owed_samples.push_back(play_tick());
        default: ;
      endcase
    end
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.sample_out = out_bus.sample_out;
      got.active     = out_bus.active;
      if (owed_samples.size() == 0) begin
        $error("unexpected output beat: sample_out %0d active %0d",
               got.sample_out, got.active);
        mismatches++;
      end else begin
        want = owed_samples.pop_front();
        if (got.sample_out !== want.sample_out) begin
          $error("sample_out: expected %0d, got %0d", want.sample_out, got.sample_out);
          mismatches++;
        end
        if (got.active !== want.active) begin
          $error("active: expected %0d, got %0d", want.active, got.active);
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    // The register took the value at the rising edge just passed.
    case (idx)
      lsp_pkg::REG_RATE:          sh_rate = longint'($signed(value[23:0]));
      lsp_pkg::REG_LOOP_START:    sh_loop_start = value[15:0];
      lsp_pkg::REG_LOOP_END:
        sh_loop_end = (value[16:0] > lsp_pkg::INDEX_CAP) ? lsp_pkg::INDEX_CAP : value[16:0];
      lsp_pkg::REG_SAMPLE_LENGTH:
        sh_length = (value[16:0] > lsp_pkg::INDEX_CAP) ? lsp_pkg::INDEX_CAP : value[16:0];
      lsp_pkg::REG_ONE_SHOT:      sh_one_shot = value[0];
      lsp_pkg::REG_INTERP_MODE:   sh_cubic = value[0];
      lsp_pkg::REG_SAMPLE_VALID:  sh_valid = value[0];
      default: ;
    endcase
  endtask

  task automatic queue_beat(lsp_pkg::op_e op, logic [15:0] address,
                            logic signed [15:0] data);
    voice_item_t it;
    it.op      = op;
    it.address = address;
    it.data    = data;
    pending_items.push_back(it);
  endtask

  // Waits until every beat went out and every sample came back, then lets the
  // voice finish any load or trigger still in flight.
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_bus.valid || owed_samples.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
  endtask

  // A random window setting. Taps stay in RAM words 0..255, which are all
  // written first; wide limits pair with a narrow partner or an empty window.
  task automatic configure_voice(int unsigned phase);
    logic [31:0] rate_v, start_v, end_v, len_v;
    case ($urandom_range(5))
      0: rate_v = 32'h7fffff;
      1: rate_v = 32'h800000;
      2: rate_v = 32'h0;
      3: rate_v = 32'hff0000;
      default: rate_v = $urandom_range(1, 200000) * (($urandom_range(1)) ? 1 : -1);
    endcase
    start_v = ($urandom_range(7) == 0) ? 32'hffff : $urandom_range(200);
    end_v   = $urandom_range(256);
    len_v   = $urandom_range(256);
    case (phase % 4)
      1: end_v = ($urandom_range(1)) ? 32'h10000 : 32'h1ffff;
      2: len_v = ($urandom_range(1)) ? 32'h10000 : 32'h1ffff;
      3: len_v = 0;
      default: ;
    endcase
    write_reg(lsp_pkg::REG_RATE, rate_v);
    write_reg(lsp_pkg::REG_LOOP_START, start_v);
    write_reg(lsp_pkg::REG_LOOP_END, end_v);
    write_reg(lsp_pkg::REG_SAMPLE_LENGTH, len_v);
    write_reg(lsp_pkg::REG_ONE_SHOT, $urandom_range(1));
    write_reg(lsp_pkg::REG_INTERP_MODE, $urandom_range(1));
    write_reg(lsp_pkg::REG_SAMPLE_VALID, 32'($urandom_range(5) != 0));
  endtask

  initial begin
    int unsigned r;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill the window area of the RAM, with both full-scale words in it.
    for (int i = 0; i < 256; i++) begin
      queue_beat(lsp_pkg::OP_LOAD, 16'(i), (i % 3 == 0) ? 16'sh7fff :
                                           (i % 3 == 1) ? 16'sh8000 : 16'($urandom));
    end
    wait_idle();

    // Directed part: loop window, silent voice, ignored op, top address.
    write_reg(lsp_pkg::REG_LOOP_START, 10);
    write_reg(lsp_pkg::REG_LOOP_END, 20);
    write_reg(lsp_pkg::REG_SAMPLE_LENGTH, 256);
    queue_beat(lsp_pkg::OP_TICK, 0, 0);
    queue_beat(lsp_pkg::OP_TRIGGER, 0, 0);
    queue_beat(lsp_pkg::OP_TICK, 0, 0);
    wait_idle();
    write_reg(lsp_pkg::REG_SAMPLE_VALID, 1);
    write_reg(lsp_pkg::REG_RATE, 32'h18000);
    queue_beat(lsp_pkg::OP_LOAD, 16'hffff, 16'sh7fff);
    queue_beat(lsp_pkg::OP_NONE, 16'hffff, 16'shffff);
    queue_beat(lsp_pkg::OP_TRIGGER, 0, 0);
    repeat (8) queue_beat(lsp_pkg::OP_TICK, 0, 0);
    wait_idle();
    write_reg(lsp_pkg::REG_INTERP_MODE, 1);
    write_reg(lsp_pkg::REG_ONE_SHOT, 1);
    queue_beat(lsp_pkg::OP_TRIGGER, 0, 0);
    repeat (8) queue_beat(lsp_pkg::OP_TICK, 0, 0);
    wait_idle();

    // Random part: bursts of play between triggers, with loads and noise.
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin
        sender_idle_pct = 58;
        recv_idle_pct   = 7;
      end else if (phase == 8) begin
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
      end
      configure_voice(phase);
      queue_beat(lsp_pkg::OP_TRIGGER, 0, 0);
      for (int n = 0; n < 110; n++) begin
        r = $urandom_range(99);
        if (r < 6) begin
          queue_beat(lsp_pkg::OP_TRIGGER, 16'($urandom), 16'($urandom));
        end else if (r < 12) begin
          queue_beat(lsp_pkg::OP_LOAD, 16'($urandom_range(255)), 16'($urandom));
        end else if (r < 16) begin
          queue_beat(lsp_pkg::OP_LOAD, 16'($urandom), 16'($urandom));
        end else if (r < 18) begin
          queue_beat(lsp_pkg::OP_NONE, 16'($urandom), 16'($urandom));
        end else begin
          queue_beat(lsp_pkg::OP_TICK, 16'($urandom), 16'($urandom));
        end
      end
      // Starve the output for a while so the voice backs up onto its input.
      if (phase == 9) begin
        hold_off_req = 500;
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[files.f]
hw/rtl/lsp_pkg.sv
hw/rtl/lsp_if.sv
hw/rtl/lsp_ram.sv
hw/rtl/looping_sample_player_top.sv
verif/looping_sample_player_top_tb.sv
